// ===== hdl/fmc_pkg.sv =====
// Shared types, register codes and helpers of the flashlight mode controller.
package fmc_pkg;

   localparam int unsigned DEBOUNCE_SAMPLES_DEFAULT = 4;
   localparam int unsigned MODE_COUNT               = 5;
   localparam int unsigned LOW_READINGS_NEEDED      = 4;
   localparam int unsigned LEVEL_ENTRIES            = 5;

   localparam int unsigned LEVEL_W   = 8;
   localparam int unsigned MODE_W    = 3;
   localparam int unsigned TABLE_W   = LEVEL_ENTRIES * LEVEL_W;
   localparam int unsigned TURBO_W   = 16;
   localparam int unsigned COUNT_W   = 8;
   localparam int unsigned RUN_W     = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned REQ_W     = 16;
   localparam int unsigned RSP_W     = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_TABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURBO_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BATT_LOW       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BATT_CRITICAL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BATT_DELAY     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS     = 3'd5;

   // register reset values
   localparam logic [TABLE_W-1:0] LEVEL_TABLE_RESET   = 40'hFF_7D_20_10_00;
   localparam logic [TURBO_W-1:0] TURBO_LIMIT_RESET   = 16'd5625;
   localparam logic [7:0]         BATT_LOW_RESET      = 8'd130;
   localparam logic [7:0]         BATT_CRIT_RESET     = 8'd120;
   localparam logic [7:0]         BATT_DELAY_RESET    = 8'd188;
   localparam logic [7:0]         LONG_PRESS_RESET    = 8'd32;

   localparam logic [LEVEL_W-1:0] LEVEL_TURBO = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_OFF   = 8'd0;

   typedef struct packed {
      logic [TABLE_W-1:0] level_table;
      logic [TURBO_W-1:0] turbo_limit;
      logic [7:0]         battery_low_level;
      logic [7:0]         battery_critical_level;
      logic [7:0]         battery_check_delay;
      logic [7:0]         long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] pwm_level;
      logic [MODE_W-1:0]  mode_number;
      logic               sleeping;
      logic               start_conversion;
   } result_type;

   // level of a mode; modes past the table read as off
   function automatic logic [LEVEL_W-1:0] level_of(input logic [TABLE_W-1:0] tbl,
                                                   input logic [MODE_W-1:0]  m);
      logic [TABLE_W-1:0] shifted;
      shifted = tbl >> {m, 3'b000};
      if (m >= MODE_W'(LEVEL_ENTRIES))
         return LEVEL_OFF;
      return shifted[LEVEL_W-1:0];
   endfunction

   function automatic logic [MODE_W-1:0] mode_up(input logic [MODE_W-1:0] m);
      logic [MODE_W:0] nxt;
      nxt = {1'b0, m} + 1'b1;
      if (nxt >= (MODE_W+1)'(MODE_COUNT))
         return '0;
      return nxt[MODE_W-1:0];
   endfunction

   function automatic logic [MODE_W-1:0] mode_down(input logic [MODE_W-1:0] m);
      if (m == '0 || {1'b0, m} >= (MODE_W+1)'(MODE_COUNT))
         return MODE_W'(MODE_COUNT - 1);
      return m - 1'b1;
   endfunction

endpackage

// ===== hdl/fmc_csr.sv =====
// Configuration register file of the flashlight mode controller.
module fmc_csr
   import fmc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [TABLE_W-1:0]   wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_LEVEL_TABLE:   cfg_in.level_table            = wr_data;
            CSR_TURBO_LIMIT:   cfg_in.turbo_limit            = wr_data[TURBO_W-1:0];
            CSR_BATT_LOW:      cfg_in.battery_low_level      = wr_data[7:0];
            CSR_BATT_CRITICAL: cfg_in.battery_critical_level = wr_data[7:0];
            CSR_BATT_DELAY:    cfg_in.battery_check_delay    = wr_data[7:0];
            CSR_LONG_PRESS:    cfg_in.long_press_ticks       = wr_data[7:0];
            default:           cfg_in = cfg_ff;  // unmapped index: drop
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_table            <= LEVEL_TABLE_RESET;
         cfg_ff.turbo_limit            <= TURBO_LIMIT_RESET;
         cfg_ff.battery_low_level      <= BATT_LOW_RESET;
         cfg_ff.battery_critical_level <= BATT_CRIT_RESET;
         cfg_ff.battery_check_delay    <= BATT_DELAY_RESET;
         cfg_ff.long_press_ticks       <= LONG_PRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/fmc_core.sv =====
// Per-tick state update: debounce, press timing, turbo timeout, battery check, sleep.
module fmc_core
   import fmc_pkg::*;
#(
   parameter int unsigned DEBOUNCE_SAMPLES = DEBOUNCE_SAMPLES_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       switch_down,
   input  logic       conversion_done,
   input  logic [7:0] battery_reading,
   input  cfg_type    cfg,
   output result_type result
);

   logic [DEBOUNCE_SAMPLES-1:0] hist_ff, hist_in, hist_sh;
   logic [COUNT_W-1:0]          held_ff, held_in, held_inc, wait_dec;
   logic [MODE_W-1:0]           mode_ff, mode_in, mode_turbo, mode_batt;
   logic [TURBO_W-1:0]          turbo_ff, turbo_in, turbo_inc;
   logic [COUNT_W-1:0]          wait_ff, wait_in;
   logic [RUN_W-1:0]            run_ff, run_in, run_upd;
   logic                        asleep_ff, asleep_in;
   logic                        armed_ff, armed_in;
   logic                        run, pressed, start, turbo_step, low_step;
   logic [7:0]                  thr;

   // one debounce sample: shift raw switch into the history
   assign hist_sh = DEBOUNCE_SAMPLES'({hist_ff, switch_down});

   assign held_inc  = (held_ff != '1) ? held_ff + 1'b1 : held_ff;
   assign turbo_inc = (turbo_ff != '1) ? turbo_ff + 1'b1 : turbo_ff;
   assign wait_dec  = (wait_ff != '0) ? wait_ff - 1'b1 : wait_ff;

   assign turbo_step = (level_of(cfg.level_table, mode_ff) == LEVEL_TURBO)
                       && (turbo_inc > cfg.turbo_limit);
   assign mode_turbo = turbo_step ? mode_down(mode_ff) : mode_ff;
   assign thr        = (mode_turbo == MODE_W'(1)) ? cfg.battery_critical_level
                                                  : cfg.battery_low_level;

   always_comb begin
      if (!conversion_done)
         run_upd = run_ff;
      else if (battery_reading < thr)
         run_upd = (run_ff != '1) ? run_ff + 1'b1 : run_ff;
      else
         run_upd = '0;
   end

   assign low_step  = (run_upd >= RUN_W'(LOW_READINGS_NEEDED));
   assign mode_batt = low_step ? mode_down(mode_turbo) : mode_turbo;

   always_comb begin
      hist_in   = hist_ff;
      held_in   = held_ff;
      mode_in   = mode_ff;
      turbo_in  = turbo_ff;
      wait_in   = wait_ff;
      run_in    = run_ff;
      asleep_in = asleep_ff;
      armed_in  = armed_ff;
      run       = 1'b1;
      pressed   = 1'b0;
      start     = 1'b0;

      if (asleep_ff) begin
         run = 1'b0;
         if (!armed_ff) begin
            // wait for the switch to read released
            held_in = '0;
            hist_in = hist_sh;
            if (hist_sh == '0)
               armed_in = 1'b1;
         end else if (switch_down) begin
            asleep_in = 1'b0;
            armed_in  = 1'b0;
            run       = 1'b1;
         end
      end

      if (run) begin
         hist_in = hist_sh;
         pressed = (hist_sh != '0);
         if (pressed) begin
            held_in  = held_inc;
            if (held_inc == cfg.long_press_ticks)
               mode_in = mode_down(mode_ff);
            turbo_in = '0;
            wait_in  = cfg.battery_check_delay;
         end else begin
            if (held_ff != '0 && held_ff < cfg.long_press_ticks) begin
               mode_in = mode_up(mode_ff);
            end else begin
               if (level_of(cfg.level_table, mode_ff) == LEVEL_TURBO)
                  turbo_in = turbo_inc;
               mode_in = mode_turbo;
               wait_in = wait_dec;
               if (wait_dec == '0) begin
                  run_in  = run_upd;
                  mode_in = mode_batt;
                  if (low_step) begin
                     run_in  = '0;
                     wait_in = cfg.battery_check_delay;
                  end
                  start = 1'b1;
               end
            end
            held_in = '0;
         end
         // change into an off mode: go to sleep
         if (mode_in != mode_ff && level_of(cfg.level_table, mode_in) == LEVEL_OFF) begin
            asleep_in = 1'b1;
            armed_in  = 1'b0;
            held_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= '0;
         held_ff   <= '0;
         mode_ff   <= '0;
         turbo_ff  <= '0;
         wait_ff   <= BATT_DELAY_RESET;
         run_ff    <= '0;
         asleep_ff <= 1'b1;
         armed_ff  <= 1'b0;
      end else if (step_en) begin
         hist_ff   <= hist_in;
         held_ff   <= held_in;
         mode_ff   <= mode_in;
         turbo_ff  <= turbo_in;
         wait_ff   <= wait_in;
         run_ff    <= run_in;
         asleep_ff <= asleep_in;
         armed_ff  <= armed_in;
      end
   end

   assign result.pwm_level        = level_of(cfg.level_table, mode_in);
   assign result.mode_number      = mode_in;
   assign result.sleeping         = asleep_in;
   assign result.start_conversion = start;

endmodule

// ===== hdl/flashlight_mode_controller.sv =====
// Flashlight mode controller top level: stream channels, config port, result register.
//
// One req word per 16 ms tick carries the raw switch sample and the battery
// converter status and reading; each accepted word yields exactly one rsp
// word with the PWM level, mode number, sleep flag and conversion request.
// The csr channel writes the configuration registers by index (always ready);
// write only while no tick is in flight.
// The rsp word is registered and appears in the cycle after its req word is accepted.
// Throughput: one word per cycle unless rsp stalls; the state update is a single
// pass of compare-and-count logic between the state registers and the rsp register.
// Stall: while rsp_tvalid is high and rsp_tready low, the rsp word holds and
// req_tready drops; a word is taken in the same cycle the held word leaves.
// Reset: configuration returns to its defaults, the block starts asleep in
// mode 0 and waits for a release and then a press.
module flashlight_mode_controller
   import fmc_pkg::*;
#(
   parameter int unsigned DEBOUNCE_SAMPLES = DEBOUNCE_SAMPLES_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [0] switch_down, [1] conversion_done, [9:2] battery_reading, [15:10] zero
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [7:0] pwm_level, [10:8] mode_number, [11] sleeping,
   // [12] start_conversion, [15:13] zero
   output logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TABLE_W-1:0]   csr_data
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   fmc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   fmc_core #(
      .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .step_en         (accept),
      .switch_down     (req_tdata[0]),
      .conversion_done (req_tdata[1]),
      .battery_reading (req_tdata[9:2]),
      .cfg             (cfg),
      .result          (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   // load the result word on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept)
         rsp_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.start_conversion, rsp_ff.sleeping,
                        rsp_ff.mode_number, rsp_ff.pwm_level};

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the flashlight mode controller: stream stimulus and result checks.
`timescale 1ns / 100ps

module tb;
   import fmc_pkg::*;

   localparam int PHASES       = 8;
   localparam int PHASE_TICKS  = 250;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AFTER   = 600;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic               sw;
      logic               done;
      logic [7:0]         rd;
      logic               fixed;
      result_type         want;
   } switch_tick_type;

   typedef enum logic { ROW_TICK, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type       kind;
      switch_tick_type    tick;
      logic [CSR_IDX_W-1:0] idx;
      logic [TABLE_W-1:0] val;
   } script_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TABLE_W-1:0]   csr_data = '0;

   // predicted lamp state and register copy
   cfg_type                             lamp_cfg;
   logic [DEBOUNCE_SAMPLES_DEFAULT-1:0] sw_hist;
   logic [COUNT_W-1:0]                  hold_cnt;
   logic [MODE_W-1:0]                   cur_mode;
   logic [TURBO_W-1:0]                  turbo_run;
   logic [COUNT_W-1:0]                  batt_delay_left;
   logic [RUN_W-1:0]                    low_streak;
   logic                                is_asleep;
   logic                                wake_ready;

   switch_tick_type pending_ticks[$];
   result_type      lamp_expect_q[$];
   script_row_type  script[$];
   switch_tick_type offered;

   int   mismatches = 0;
   int   req_gap = 0;
   int   rsp_hold = 0;
   int   rsp_taken = 0;
   logic long_hold_done = 1'b0;
   logic calm = 1'b0;

   flashlight_mode_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [LEVEL_W-1:0] table_level(input logic [MODE_W-1:0] m);
      if (int'(m) >= LEVEL_ENTRIES) return LEVEL_OFF;
      return lamp_cfg.level_table[LEVEL_W*m +: LEVEL_W];
   endfunction

   function automatic logic [MODE_W-1:0] next_mode_up(input logic [MODE_W-1:0] m);
      if (int'(m) + 1 >= MODE_COUNT) return '0;
      return m + 1'b1;
   endfunction

   function automatic logic [MODE_W-1:0] next_mode_down(input logic [MODE_W-1:0] m);
      if (m == '0 || int'(m) >= MODE_COUNT) return MODE_W'(MODE_COUNT - 1);
      return m - 1'b1;
   endfunction

   // advance the predicted lamp by one tick and return its output word
   task automatic lamp_step(input logic sw, input logic done, input logic [7:0] rd,
                            output result_type r);
      logic               run;
      logic               start;
      logic [MODE_W-1:0]  prev;
      logic [7:0]         thr;
      run = 1'b1;
      start = 1'b0;
      if (is_asleep) begin
         run = 1'b0;
         if (!wake_ready) begin
            hold_cnt = '0;
            sw_hist = (sw_hist << 1) | DEBOUNCE_SAMPLES_DEFAULT'(sw);
            if (sw_hist == '0) wake_ready = 1'b1;
         end else if (sw) begin
            is_asleep = 1'b0;
            wake_ready = 1'b0;
            run = 1'b1;
         end
      end
      if (run) begin
         prev = cur_mode;
         sw_hist = (sw_hist << 1) | DEBOUNCE_SAMPLES_DEFAULT'(sw);
         if (sw_hist != '0) begin
            if (hold_cnt != '1) hold_cnt++;
            if (hold_cnt == lamp_cfg.long_press_ticks) cur_mode = next_mode_down(cur_mode);
            turbo_run = '0;
            batt_delay_left = lamp_cfg.battery_check_delay;
         end else begin
            if (hold_cnt > 0 && hold_cnt < lamp_cfg.long_press_ticks) begin
               cur_mode = next_mode_up(cur_mode);
            end else begin
               if (table_level(cur_mode) == LEVEL_TURBO) begin
                  if (turbo_run != '1) turbo_run++;
                  if (turbo_run > lamp_cfg.turbo_limit) cur_mode = next_mode_down(cur_mode);
               end
               if (batt_delay_left > 0) batt_delay_left--;
               if (batt_delay_left == 0) begin
                  if (done) begin
                     thr = (cur_mode == MODE_W'(1)) ? lamp_cfg.battery_critical_level
                                                    : lamp_cfg.battery_low_level;
                     if (rd < thr) begin
                        if (low_streak != '1) low_streak++;
                     end else begin
                        low_streak = '0;
                     end
                  end
                  if (int'(low_streak) >= LOW_READINGS_NEEDED) begin
                     cur_mode = next_mode_down(cur_mode);
                     low_streak = '0;
                     batt_delay_left = lamp_cfg.battery_check_delay;
                  end
                  start = 1'b1;
               end
            end
            hold_cnt = '0;
         end
         // entering an off level puts the lamp to sleep
         if (cur_mode != prev && table_level(cur_mode) == LEVEL_OFF) begin
            is_asleep = 1'b1;
            wake_ready = 1'b0;
            hold_cnt = '0;
         end
      end
      r.pwm_level = table_level(cur_mode);
      r.mode_number = cur_mode;
      r.sleeping = is_asleep;
      r.start_conversion = start;
   endtask

   function automatic logic [7:0] pick_reading();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return lamp_cfg.battery_low_level + 8'($urandom_range(0, 4)) - 8'd2;
      if (r < 6) return lamp_cfg.battery_critical_level + 8'($urandom_range(0, 4)) - 8'd2;
      if (r == 6) return 8'd0;
      if (r == 7) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_tick(input logic sw, input logic sag = 1'b0);
      switch_tick_type t;
      t.sw = sw;
      t.done = ($urandom_range(0, 9) < 7);
      t.rd = sag ? 8'($urandom_range(0, 3)) : pick_reading();
      t.fixed = 1'b0;
      t.want = '0;
      pending_ticks.push_back(t);
   endtask

   task automatic add_tick(input logic sw, input logic done, input logic [7:0] rd,
                           input logic fixed = 1'b0, input result_type want = '0);
      script_row_type row;
      row.kind = ROW_TICK;
      row.tick.sw = sw;
      row.tick.done = done;
      row.tick.rd = rd;
      row.tick.fixed = fixed;
      row.tick.want = want;
      row.idx = '0;
      row.val = '0;
      script.push_back(row);
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [TABLE_W-1:0] val);
      script_row_type row;
      row.kind = ROW_CSR;
      row.tick = '{default: '0};
      row.idx = idx;
      row.val = val;
      script.push_back(row);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [TABLE_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LEVEL_TABLE:   lamp_cfg.level_table = val;
         CSR_TURBO_LIMIT:   lamp_cfg.turbo_limit = val[TURBO_W-1:0];
         CSR_BATT_LOW:      lamp_cfg.battery_low_level = val[7:0];
         CSR_BATT_CRITICAL: lamp_cfg.battery_critical_level = val[7:0];
         CSR_BATT_DELAY:    lamp_cfg.battery_check_delay = val[7:0];
         CSR_LONG_PRESS:    lamp_cfg.long_press_ticks = val[7:0];
         default: ;
      endcase
   endtask

   // sample at the falling edge so all rising-edge updates have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || lamp_expect_q.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : req_drive
      result_type want;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            lamp_step(offered.sw, offered.done, offered.rd, want);
            if (offered.fixed) want = offered.want;
            lamp_expect_q.push_back(want);
            req_gap = pick_gap();
         end
         if (req_tvalid && !req_tready) begin
            // hold the offered word
         end else if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            offered = pending_ticks.pop_front();
            req_tdata <= {6'b0, offered.rd, offered.done, offered.sw};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_drive
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken++;
            rsp_hold = pick_gap();
         end
         // stall the result side once while the sender keeps offering
         if (!long_hold_done && rsp_taken >= HOLD_AFTER && pending_ticks.size() > 50) begin
            rsp_hold = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (lamp_expect_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = lamp_expect_q.pop_front();
            check_field("pwm_level", want.pwm_level, rsp_tdata[7:0]);
            check_field("mode_number", want.mode_number, rsp_tdata[10:8]);
            check_field("sleeping", want.sleeping, rsp_tdata[11]);
            check_field("start_conversion", want.start_conversion, rsp_tdata[12]);
         end
      end
   end

   initial begin : main
      cfg_type    pick;
      int         phase;
      int         made;
      int         r;
      int         e;
      int         lp;
      int         plen;
      int         rlen;
      logic       sag;
      logic [7:0] b;

      lamp_cfg = {LEVEL_TABLE_RESET, TURBO_LIMIT_RESET, BATT_LOW_RESET, BATT_CRIT_RESET,
                  BATT_DELAY_RESET, LONG_PRESS_RESET};
      sw_hist = '0;
      hold_cnt = '0;
      cur_mode = '0;
      turbo_run = '0;
      batt_delay_left = BATT_DELAY_RESET;
      low_streak = '0;
      is_asleep = 1'b1;
      wake_ready = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // released switch arms the wake, a press wakes in mode 0
      add_tick(1'b0, 1'b0, 8'd0,   1'b1, result_type'{LEVEL_OFF, 3'd0, 1'b1, 1'b0});
      add_tick(1'b1, 1'b1, 8'd255, 1'b1, result_type'{LEVEL_OFF, 3'd0, 1'b0, 1'b0});
      // debounce tail, then a short press advances
      add_tick(1'b0, 1'b1, 8'd0);
      add_tick(1'b0, 1'b0, 8'd255);
      add_tick(1'b0, 1'b0, 8'd0);
      add_tick(1'b0, 1'b1, 8'd255);
      // zero long press: no press counts
      add_csr(CSR_LONG_PRESS, TABLE_W'(0));
      add_tick(1'b1, 1'b0, 8'd0);
      add_tick(1'b1, 1'b0, 8'd0);
      add_tick(1'b0, 1'b0, 8'd0);
      add_tick(1'b0, 1'b0, 8'd0);
      add_tick(1'b0, 1'b0, 8'd0);
      add_tick(1'b0, 1'b0, 8'd0);
      add_csr(CSR_UNUSED, '1);
      // long press at once: step back to off and sleep
      add_csr(CSR_LONG_PRESS, TABLE_W'(1));
      add_tick(1'b1, 1'b0, 8'd0);
      add_tick(1'b0, 1'b0, 8'd0);
      add_tick(1'b0, 1'b0, 8'd0);
      add_tick(1'b0, 1'b0, 8'd0);
      add_tick(1'b0, 1'b0, 8'd0);
      // wake with a long press that wraps to turbo; turbo times out at once
      add_csr(CSR_TURBO_LIMIT, TABLE_W'(0));
      add_csr(CSR_BATT_DELAY, TABLE_W'(1));
      add_tick(1'b1, 1'b0, 8'd0);
      add_tick(1'b0, 1'b1, 8'd200);
      add_tick(1'b0, 1'b1, 8'd200);
      add_tick(1'b0, 1'b1, 8'd200);
      add_tick(1'b0, 1'b1, 8'd200);
      // four low readings step down
      add_tick(1'b0, 1'b1, 8'd0);
      add_tick(1'b0, 1'b1, 8'd0);
      add_tick(1'b0, 1'b1, 8'd0);
      add_tick(1'b0, 1'b1, 8'd0);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            wait_drained();
            csr_write(script[i].idx, script[i].val);
         end else begin
            pending_ticks.push_back(script[i].tick);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: pick = {TABLE_W'(0), 16'd0, 8'd0, 8'd0, 8'd0, 8'd1};
            1: pick = {40'hFF_FF_FF_FF_FF, 16'd65534, 8'd255, 8'd255, 8'd255, 8'd255};
            2: pick = {LEVEL_TABLE_RESET, 16'd20, BATT_LOW_RESET, BATT_CRIT_RESET, 8'd5, 8'd6};
            default: begin
               for (e = 0; e < LEVEL_ENTRIES; e++) begin
                  r = $urandom_range(0, 99);
                  if (r < 15) b = LEVEL_OFF;
                  else if (r < 30) b = LEVEL_TURBO;
                  else b = 8'($urandom_range(0, 255));
                  pick.level_table[LEVEL_W*e +: LEVEL_W] = b;
               end
               if ($urandom_range(0, 99) < 85) pick.level_table[LEVEL_W-1:0] = LEVEL_OFF;
               r = $urandom_range(0, 99);
               pick.turbo_limit = (r < 90) ? 16'($urandom_range(0, 30))
                                           : 16'($urandom_range(31, 65534));
               pick.battery_low_level = 8'($urandom_range(0, 255));
               pick.battery_critical_level = 8'($urandom_range(0, 255));
               r = $urandom_range(0, 99);
               pick.battery_check_delay = (r < 90) ? 8'($urandom_range(0, 15))
                                                   : 8'($urandom_range(16, 255));
               r = $urandom_range(0, 99);
               if (r < 5) pick.long_press_ticks = 8'd0;
               else if (r < 10) pick.long_press_ticks = 8'd255;
               else pick.long_press_ticks = 8'($urandom_range(1, 12));
            end
         endcase
         csr_write(CSR_LEVEL_TABLE, pick.level_table);
         csr_write(CSR_TURBO_LIMIT, TABLE_W'(pick.turbo_limit));
         csr_write(CSR_BATT_LOW, TABLE_W'(pick.battery_low_level));
         csr_write(CSR_BATT_CRITICAL, TABLE_W'(pick.battery_critical_level));
         csr_write(CSR_BATT_DELAY, TABLE_W'(pick.battery_check_delay));
         csr_write(CSR_LONG_PRESS, TABLE_W'(pick.long_press_ticks));
         calm = (phase == 3 || phase == 6);

         made = 0;
         while (made < PHASE_TICKS) begin
            if ($urandom_range(0, 99) < 75) begin
               // press and release with random battery traffic
               lp = int'(lamp_cfg.long_press_ticks);
               r = $urandom_range(0, 99);
               if (r < 85) plen = $urandom_range(1, lp + 8);
               else if (r < 97) plen = $urandom_range(lp, lp + 30);
               else plen = $urandom_range(250, 280);
               if ($urandom_range(0, 9) == 0)
                  rlen = $urandom_range(1, int'(lamp_cfg.battery_check_delay) + 20);
               else
                  rlen = $urandom_range(1, 40);
               sag = ($urandom_range(0, 3) == 0);
               repeat (plen) queue_tick(1'b1);
               repeat (rlen) queue_tick(1'b0, sag);
               made += plen + rlen;
            end else begin
               rlen = $urandom_range(1, 8);
               repeat (rlen) queue_tick(1'($urandom_range(0, 1)));
               made += rlen;
            end
         end
      end

      wait_drained();
      repeat (3) @(posedge clock);
      if (mismatches == 0 && lamp_expect_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
